FILE: rtl/rrbc_pkg.sv
// ----------------------------------------------------------------------------
// rrbc_pkg
// Shared constants and types of the ROM/RAM bank controller.
// ----------------------------------------------------------------------------
package rrbc_pkg;

    localparam int ROM_ADDR_BITS_DEF = 21;
    localparam int RAM_ADDR_BITS_DEF = 15;

    // Width of the mapped ROM address (7-bit bank, 14-bit offset)
    localparam int ROM_MAP_BITS = 21;
    // Width of the mapped RAM index (2-bit bank, 13-bit offset)
    localparam int RAM_MAP_BITS = 15;

    // Bus request codes
    localparam logic [2:0] CMD_ROM_RD  = 3'd0;
    localparam logic [2:0] CMD_CTRL_WR = 3'd1;
    localparam logic [2:0] CMD_RAM_RD  = 3'd2;
    localparam logic [2:0] CMD_RAM_WR  = 3'd3;
    localparam logic [2:0] CMD_ROM_LD  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAPPER_KIND   = 2'd0;
    localparam logic [1:0] CFG_ROM_SIZE_CODE = 2'd1;
    localparam logic [1:0] CFG_RAM_SIZE_CODE = 2'd2;

    // RAM size codes
    localparam logic [1:0] RAM_SIZE_NONE = 2'd0;
    localparam logic [1:0] RAM_SIZE_2K   = 2'd1;
    localparam logic [1:0] RAM_SIZE_8K   = 2'd2;
    localparam logic [1:0] RAM_SIZE_32K  = 2'd3;

    localparam logic [3:0] RAM_ENABLE_KEY = 4'ha;

    typedef struct packed {
        logic       mapper_kind;
        logic [2:0] rom_size_code;
        logic [1:0] ram_size_code;
    } cfg_t;

    typedef struct packed {
        logic                    ram_on;
        logic                    ram_present;
        logic [6:0]              rom_bank;
        logic [ROM_MAP_BITS-1:0] rom_addr;
        logic [RAM_MAP_BITS-1:0] ram_idx;
    } map_t;

endpackage

FILE: rtl/rrbc_map.sv
// ----------------------------------------------------------------------------
// rrbc_map
// Bank mapping: turns the control bytes, the configuration and a bus address
// into the ROM address, the RAM index and the status bits.
// ----------------------------------------------------------------------------
module rrbc_map
    import rrbc_pkg::*;
(
    input  cfg_t        cfg,
    input  logic [7:0]  bank_regs [4],
    input  logic [14:0] addr,
    output map_t        map
);

    logic [4:0]              low_bank;
    logic [6:0]              raw_bank;
    logic [6:0]              bank;
    logic [8:0]              bank_mask;
    logic                    upper_to_ram;
    logic [1:0]              ram_bank;
    logic [RAM_MAP_BITS-1:0] ram_mask;

    always_comb begin
        upper_to_ram = cfg.mapper_kind && bank_regs[3][0];

        // low bank of zero selects bank 1
        low_bank = bank_regs[1][4:0];
        if (low_bank == 5'd0) begin
            low_bank = 5'd1;
        end

        if (!cfg.mapper_kind) begin
            raw_bank = 7'd1;
        end else if (upper_to_ram) begin
            raw_bank = {2'b00, low_bank};
        end else begin
            raw_bank = {bank_regs[2][1:0], low_bank};
        end

        // ROM holds 2 << code banks
        bank_mask = (9'd2 << cfg.rom_size_code) - 9'd1;
        bank      = raw_bank & bank_mask[6:0];

        ram_bank = upper_to_ram ? bank_regs[2][1:0] : 2'b00;
        case (cfg.ram_size_code)
            RAM_SIZE_2K:  ram_mask = 15'h07ff;
            RAM_SIZE_8K:  ram_mask = 15'h1fff;
            RAM_SIZE_32K: ram_mask = 15'h7fff;
            default:      ram_mask = 15'h0000;
        endcase

        map.ram_on      = (bank_regs[0][3:0] == RAM_ENABLE_KEY);
        map.ram_present = (cfg.ram_size_code != RAM_SIZE_NONE);
        map.rom_bank    = bank;
        map.rom_addr    = addr[14] ? {bank, addr[13:0]} : {6'd0, addr};
        map.ram_idx     = {ram_bank, addr[12:0]} & ram_mask;
    end

endmodule

FILE: rtl/rom_ram_bank_controller.sv
// ----------------------------------------------------------------------------
// rom_ram_bank_controller
// An accepted request passes through stage 1 (array read and read source)
// and then the output register. Throughput: one request per cycle while
// results are taken; the single port of the ROM or RAM array serves one
// access per request. Reset clears the control bytes, configuration and
// pipeline valids; ROM and RAM contents are kept and need no clearing pass.
// ----------------------------------------------------------------------------
module rom_ram_bank_controller
    import rrbc_pkg::*;
#(
    parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEF,
    parameter int RAM_ADDR_BITS = RAM_ADDR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [14:0] s_addr,
    input  logic [7:0]  s_write_data,
    input  logic [20:0] s_rom_index,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic        m_ram_enabled,
    output logic [6:0]  m_rom_bank
);

    // read source of a request in flight
    localparam logic [1:0] SRC_ZERO = 2'd0;
    localparam logic [1:0] SRC_ROM  = 2'd1;
    localparam logic [1:0] SRC_RAM  = 2'd2;
    localparam logic [1:0] SRC_FF   = 2'd3;

    cfg_t       cfg_reg;
    logic [7:0] bank_regs_reg [4];
    map_t       map;

    logic       p1_valid_reg;
    logic       p1_valid_next;
    logic [1:0] p1_src_reg;
    logic [1:0] src_next;

    logic       m_valid_reg;
    logic       m_valid_next;
    logic [7:0] m_read_data_reg;
    logic       m_ram_enabled_reg;
    logic [6:0] m_rom_bank_reg;

    logic       s_acc;
    logic       p1_adv;
    logic       ram_ok;

    logic [7:0]               rom_mem [2**ROM_ADDR_BITS];
    logic [ROM_ADDR_BITS-1:0] rom_addr;
    logic                     rom_we;
    logic                     rom_re;
    logic [7:0]               rom_rdata_reg;

    logic [7:0]               ram_mem [2**RAM_ADDR_BITS];
    logic [RAM_ADDR_BITS-1:0] ram_addr;
    logic                     ram_we;
    logic                     ram_re;
    logic [7:0]               ram_rdata_reg;

    rrbc_map u_map (
        .cfg       (cfg_reg),
        .bank_regs (bank_regs_reg),
        .addr      (s_addr),
        .map       (map)
    );

    assign cfg_ready = 1'b1;

    assign p1_adv  = !m_valid_reg || m_ready;
    assign s_ready = !p1_valid_reg || p1_adv;
    assign s_acc   = s_valid && s_ready;
    assign ram_ok  = map.ram_present && map.ram_on;

    always_comb begin
        rom_we   = s_acc && (s_cmd == CMD_ROM_LD);
        rom_re   = s_acc && (s_cmd == CMD_ROM_RD);
        rom_addr = rom_we ? ROM_ADDR_BITS'(s_rom_index) : ROM_ADDR_BITS'(map.rom_addr);
        ram_we   = s_acc && (s_cmd == CMD_RAM_WR) && ram_ok;
        ram_re   = s_acc && (s_cmd == CMD_RAM_RD) && ram_ok;
        ram_addr = RAM_ADDR_BITS'(map.ram_idx);

        case (s_cmd)
            CMD_ROM_RD: src_next = SRC_ROM;
            CMD_RAM_RD: src_next = ram_ok ? SRC_RAM : SRC_FF;
            default:    src_next = SRC_ZERO;
        endcase

        p1_valid_next = s_acc || (p1_valid_reg && !p1_adv);
        m_valid_next  = (p1_valid_reg && p1_adv) || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (rom_we) begin
            rom_mem[rom_addr] <= s_write_data;
        end
        if (rom_re) begin
            rom_rdata_reg <= rom_mem[rom_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            ram_mem[ram_addr] <= s_write_data;
        end
        if (ram_re) begin
            ram_rdata_reg <= ram_mem[ram_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MAPPER_KIND:   cfg_reg.mapper_kind   <= cfg_data[0];
                CFG_ROM_SIZE_CODE: cfg_reg.rom_size_code <= cfg_data[2:0];
                CFG_RAM_SIZE_CODE: cfg_reg.ram_size_code <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                bank_regs_reg[i] <= 8'h00;
            end
        end else if (s_acc && (s_cmd == CMD_CTRL_WR)) begin
            bank_regs_reg[s_addr[14:13]] <= s_write_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            p1_src_reg <= src_next;
        end
        // control bytes here already hold the effect of the request in stage 1
        if (p1_valid_reg && p1_adv) begin
            m_ram_enabled_reg <= map.ram_on;
            m_rom_bank_reg    <= map.rom_bank;
            case (p1_src_reg)
                SRC_ROM: m_read_data_reg <= rom_rdata_reg;
                SRC_RAM: m_read_data_reg <= ram_rdata_reg;
                SRC_FF:  m_read_data_reg <= 8'hff;
                default: m_read_data_reg <= 8'h00;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_data   = m_read_data_reg;
    assign m_ram_enabled = m_ram_enabled_reg;
    assign m_rom_bank    = m_rom_bank_reg;

endmodule

FILE: rtl/rrbc_checker.sv
// ----------------------------------------------------------------------------
// rrbc_checker
// Port-level checks of the bank controller, bound to the top level.
// ----------------------------------------------------------------------------
module rrbc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_read_data,
    input logic        m_ram_enabled,
    input logic [6:0]  m_rom_bank
);

    logic [1:0] inflight_reg;
    logic [1:0] inflight_next;

    always_comb begin
        inflight_next = inflight_reg;
        if (s_valid && s_ready) begin
            inflight_next = inflight_next + 2'd1;
        end
        if (m_valid && m_ready) begin
            inflight_next = inflight_next - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= 2'd0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data)
            && $stable(m_ram_enabled) && $stable(m_rom_bank))
        else $error("stalled result changed");

    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg != 2'd3)
        else $error("more than two requests in flight");

    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != 2'd0)
        else $error("result without a request");

endmodule

bind rom_ram_bank_controller rrbc_checker u_rrbc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_read_data   (m_read_data),
    .m_ram_enabled (m_ram_enabled),
    .m_rom_bank    (m_rom_bank)
);

FILE: bench/rom_ram_bank_controller_test.sv
// ----------------------------------------------------------------------------
// rom_ram_bank_controller_test
// Self-checking bench for the cartridge ROM/RAM bank controller. Bus
// requests go in through the s_ channel while results come back on m_; each
// result is checked against an in-bench mapper model (control bytes, bank
// selection, ROM/RAM images). A short directed table runs first, then
// randomized phases under several size/mapper settings, with idle bursts on
// both sides and one long result-side stall.
// ----------------------------------------------------------------------------
module rom_ram_bank_controller_test
    import rrbc_pkg::*;
();

    localparam int ROM_BYTES   = 1 << ROM_ADDR_BITS_DEF;
    localparam int RAM_BYTES   = 1 << RAM_ADDR_BITS_DEF;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 160;

    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    // control byte slots, picked by address bits 14:13
    localparam logic [1:0] CTL_RAM_EN   = 2'd0;
    localparam logic [1:0] CTL_ROM_BANK = 2'd1;
    localparam logic [1:0] CTL_HI_BITS  = 2'd2;
    localparam logic [1:0] CTL_MODE     = 2'd3;

    typedef struct packed {
        logic [7:0] rd;
        logic       en;
        logic [6:0] bank;
    } bus_reply_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [14:0] addr;
        logic [7:0]  data;
        logic [20:0] lidx;
        logic        typed;
        bus_reply_t  want;
    } script_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_cmd;
    logic [14:0] s_addr;
    logic [7:0]  s_write_data;
    logic [20:0] s_rom_index;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_read_data;
    logic        m_ram_enabled;
    logic [6:0]  m_rom_bank;

    // mapper model state
    logic [7:0] ctl_reg [0:3];
    logic       map_kind;
    logic [2:0] rom_code;
    logic [1:0] ram_code;
    bit [7:0]   rom_img  [0:ROM_BYTES-1];
    bit         rom_seen [0:ROM_BYTES-1];
    bit [7:0]   ram_img  [0:RAM_BYTES-1];
    bit         ram_seen [0:RAM_BYTES-1];

    bus_reply_t  replies_due [$];
    script_row_t script [$];
    bus_reply_t  got_want;
    int          errors;
    int          sent;
    int          quiet;
    bit          gaps_on;
    bit          steady;
    bit          hold_req;

    rom_ram_bank_controller DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_addr        (s_addr),
        .s_write_data  (s_write_data),
        .s_rom_index   (s_rom_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_ram_enabled (m_ram_enabled),
        .m_rom_bank    (m_rom_bank)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic bit ram_on_now();
        return ctl_reg[CTL_RAM_EN][3:0] == RAM_ENABLE_KEY;
    endfunction

    function automatic bit ram_banking();
        return map_kind && ctl_reg[CTL_MODE][0];
    endfunction

    function automatic logic [6:0] rom_bank_sel();
        logic [6:0] b;
        logic [7:0] mask;
        b = 7'd1;
        if (map_kind) begin
            b = {2'b00, ctl_reg[CTL_ROM_BANK][4:0]};
            if (b == 7'd0) b = 7'd1;
            if (!ram_banking()) b[6:5] = ctl_reg[CTL_HI_BITS][1:0];
        end
        mask = (8'd2 << rom_code) - 8'd1;
        return b & mask[6:0];
    endfunction

    function automatic int ram_span();
        case (ram_code)
            RAM_SIZE_2K:  return 'h800;
            RAM_SIZE_8K:  return 'h2000;
            RAM_SIZE_32K: return 'h8000;
            default:      return 0;
        endcase
    endfunction

    function automatic logic [14:0] ram_slot(input logic [14:0] addr);
        int idx;
        idx = (ram_banking() ? int'(ctl_reg[CTL_HI_BITS][1:0]) : 0) * 'h2000
              + int'(addr[12:0]);
        return 15'(idx & (ram_span() - 1) & (RAM_BYTES - 1));
    endfunction

    function automatic logic [20:0] rom_phys(input logic [14:0] addr);
        if (addr < 15'h4000) return {6'd0, addr};
        return {rom_bank_sel(), addr[13:0]};
    endfunction

    // Applies one bus request to the model and returns its reply.
    function automatic bus_reply_t resolve_access(input logic [2:0] cmd,
                                                  input logic [14:0] addr,
                                                  input logic [7:0] data,
                                                  input logic [20:0] lidx);
        bus_reply_t  r;
        logic [20:0] phys;
        logic [14:0] slot;
        r.rd = 8'h00;
        case (cmd)
            CMD_ROM_RD: begin
                phys = rom_phys(addr);
                r.rd = rom_img[phys];
            end
            CMD_CTRL_WR: ctl_reg[addr[14:13]] = data;
            CMD_RAM_RD: begin
                if (ram_span() == 0 || !ram_on_now()) begin
                    r.rd = 8'hff;
                end else begin
                    slot = ram_slot(addr);
                    r.rd = ram_img[slot];
                end
            end
            CMD_RAM_WR: begin
                if (ram_span() != 0 && ram_on_now()) begin
                    slot = ram_slot(addr);
                    ram_img[slot]  = data;
                    ram_seen[slot] = 1'b1;
                end
            end
            CMD_ROM_LD: begin
                rom_img[lidx]  = data;
                rom_seen[lidx] = 1'b1;
            end
            default: ;
        endcase
        r.en   = ram_on_now();
        r.bank = rom_bank_sel();
        return r;
    endfunction

    function automatic script_row_t mk_row(input logic [2:0] cmd, input logic [14:0] addr,
                                           input logic [7:0] data, input logic [20:0] lidx,
                                           input logic typed, input logic [7:0] rd,
                                           input logic en, input logic [6:0] bank);
        script_row_t row;
        row.cmd       = cmd;
        row.addr      = addr;
        row.data      = data;
        row.lidx      = lidx;
        row.typed     = typed;
        row.want.rd   = rd;
        row.want.en   = en;
        row.want.bank = bank;
        return row;
    endfunction

    task automatic offer(input logic [2:0] cmd, input logic [14:0] addr,
                         input logic [7:0] data, input logic [20:0] lidx,
                         input bus_reply_t want);
        int gap;
        if (gaps_on && !steady && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 13);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_addr       <= addr;
        s_write_data <= data;
        s_rom_index  <= lidx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        replies_due.push_back(want);
        sent++;
    endtask

    task automatic issue(input logic [2:0] cmd, input logic [14:0] addr,
                         input logic [7:0] data, input logic [20:0] lidx);
        bus_reply_t want;
        want = resolve_access(cmd, addr, data, lidx);
        offer(cmd, addr, data, lidx, want);
    endtask

    // One random request; reads of store entries never written are preceded
    // by a write to the same entry.
    task automatic random_access();
        int          pick;
        logic [14:0] a;
        logic [7:0]  d;
        logic [7:0]  d2;
        logic [20:0] li;
        logic [20:0] phys;
        logic [2:0]  c;
        pick = $urandom_range(0, 99);
        a    = 15'($urandom);
        d    = 8'($urandom);
        d2   = 8'($urandom);
        li   = 21'($urandom);
        if (pick < 35) begin
            if ($urandom_range(0, 1)) a[13:4] = '0;
            phys = rom_phys(a);
            if (!rom_seen[phys]) issue(CMD_ROM_LD, li[14:0], d2, phys);
            issue(CMD_ROM_RD, a, d, li);
        end else if (pick < 55) begin
            if (a[14:13] == CTL_RAM_EN && $urandom_range(0, 3) != 0)
                d[3:0] = RAM_ENABLE_KEY;
            issue(CMD_CTRL_WR, a, d, li);
        end else if (pick < 75) begin
            if ($urandom_range(0, 1)) a[12:4] = '0;
            if (ram_span() != 0 && ram_on_now() && !ram_seen[ram_slot(a)])
                issue(CMD_RAM_WR, a, d2, li);
            issue(CMD_RAM_RD, a, d, li);
        end else if (pick < 90) begin
            if ($urandom_range(0, 1)) a[12:4] = '0;
            issue(CMD_RAM_WR, a, d, li);
        end else if (pick < 97) begin
            issue(CMD_ROM_LD, a, d, li);
        end else begin
            c = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
            issue(c, a, d, li);
        end
    endtask

    // Drains the request side first, then writes the three settings.
    task automatic apply_setting(input logic kind, input logic [2:0] romc,
                                 input logic [1:0] ramc);
        logic [1:0] regs [0:2];
        logic [7:0] vals [0:2];
        regs[0] = CFG_MAPPER_KIND;
        regs[1] = CFG_ROM_SIZE_CODE;
        regs[2] = CFG_RAM_SIZE_CODE;
        vals[0] = {7'd0, kind};
        vals[1] = {5'd0, romc};
        vals[2] = {6'd0, ramc};
        s_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        map_kind = kind;
        rom_code = romc;
        ram_code = ramc;
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (!steady && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result rd=%h en=%b bank=%0d", $time,
                         m_read_data, m_ram_enabled, m_rom_bank);
            end else begin
                got_want = replies_due.pop_front();
                if (m_read_data !== got_want.rd) begin
                    errors++;
                    $display("%0t: read_data expected %h got %h", $time,
                             got_want.rd, m_read_data);
                end
                if (m_ram_enabled !== got_want.en) begin
                    errors++;
                    $display("%0t: ram_enabled expected %b got %b", $time,
                             got_want.en, m_ram_enabled);
                end
                if (m_rom_bank !== got_want.bank) begin
                    errors++;
                    $display("%0t: rom_bank expected %0d got %0d", $time,
                             got_want.bank, m_rom_bank);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, quiet);
            $display("[rom_ram_bank_controller] ERROR");
            $finish;
        end
    end

    initial begin
        bus_reply_t want;
        int         phase_end;
        errors   = 0;
        sent     = 0;
        quiet    = 0;
        gaps_on  = 1'b1;
        steady   = 1'b0;
        hold_req = 1'b0;
        for (int i = 0; i < 4; i++) ctl_reg[i] = 8'h00;
        map_kind = 1'b0;
        rom_code = 3'd0;
        ram_code = RAM_SIZE_NONE;
        aresetn      <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_MAPPER_KIND;
        cfg_data     <= 8'h00;
        s_valid      <= 1'b0;
        s_cmd        <= CMD_ROM_RD;
        s_addr       <= '0;
        s_write_data <= '0;
        s_rom_index  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: largest ROM, 32K RAM, banking on
        apply_setting(1'b1, 3'd6, RAM_SIZE_32K);
        script.push_back(mk_row(CMD_RAM_RD,  15'h0000, 8'h00, 21'h0,      1, 8'hff, 0, 7'd1));
        script.push_back(mk_row(CMD_ROM_LD,  15'h0000, 8'h5a, 21'h0,      1, 8'h00, 0, 7'd1));
        script.push_back(mk_row(CMD_ROM_LD,  15'h7fff, 8'ha5, 21'h1fffff, 1, 8'h00, 0, 7'd1));
        script.push_back(mk_row(CMD_ROM_RD,  15'h0000, 8'h00, 21'h0,      1, 8'h5a, 0, 7'd1));
        script.push_back(mk_row(CMD_CTRL_WR, 15'h2000, 8'hff, 21'h0,      1, 8'h00, 0, 7'd31));
        script.push_back(mk_row(CMD_CTRL_WR, 15'h4000, 8'hff, 21'h0,      1, 8'h00, 0, 7'd127));
        script.push_back(mk_row(CMD_ROM_RD,  15'h7fff, 8'hff, 21'h1fffff, 1, 8'ha5, 0, 7'd127));
        // low bank of zero reads as one
        script.push_back(mk_row(CMD_CTRL_WR, 15'h2000, 8'h00, 21'h0,      0, 0, 0, 0));
        script.push_back(mk_row(CMD_CTRL_WR, 15'h0000, 8'h0a, 21'h0,      0, 0, 0, 0));
        script.push_back(mk_row(CMD_RAM_WR,  15'h1fff, 8'h3c, 21'h0,      0, 0, 0, 0));
        script.push_back(mk_row(CMD_RAM_RD,  15'h1fff, 8'h00, 21'h0,      0, 0, 0, 0));
        // RAM mode: upper bits move to the RAM bank
        script.push_back(mk_row(CMD_CTRL_WR, 15'h6000, 8'h01, 21'h0,      0, 0, 0, 0));
        script.push_back(mk_row(CMD_RAM_WR,  15'h0000, 8'hff, 21'h0,      0, 0, 0, 0));
        script.push_back(mk_row(CMD_RAM_WR,  15'h7fff, 8'h81, 21'h0,      0, 0, 0, 0));
        script.push_back(mk_row(CMD_RAM_RD,  15'h7fff, 8'h00, 21'h0,      0, 0, 0, 0));
        script.push_back(mk_row(CMD_RAM_RD,  15'h0000, 8'h00, 21'h0,      0, 0, 0, 0));
        script.push_back(mk_row(CMD_ROM_LD,  15'h0000, 8'hc3, 21'h4000,   0, 0, 0, 0));
        script.push_back(mk_row(CMD_ROM_RD,  15'h4000, 8'h00, 21'h0,      0, 0, 0, 0));
        script.push_back(mk_row(CMD_UNUSED_LO, 15'h7fff, 8'hff, 21'h1fffff, 0, 0, 0, 0));
        script.push_back(mk_row(CMD_UNUSED_HI, 15'h7fff, 8'hff, 21'h1fffff, 0, 0, 0, 0));
        // disabled RAM: reads 0xff, writes dropped
        script.push_back(mk_row(CMD_CTRL_WR, 15'h0000, 8'hf5, 21'h0,      0, 0, 0, 0));
        script.push_back(mk_row(CMD_RAM_WR,  15'h7fff, 8'h00, 21'h0,      0, 0, 0, 0));
        script.push_back(mk_row(CMD_RAM_RD,  15'h7fff, 8'h00, 21'h0,      0, 0, 0, 0));
        script.push_back(mk_row(CMD_CTRL_WR, 15'h0000, 8'h1a, 21'h0,      0, 0, 0, 0));
        script.push_back(mk_row(CMD_RAM_RD,  15'h7fff, 8'h00, 21'h0,      0, 0, 0, 0));
        foreach (script[i]) begin
            want = resolve_access(script[i].cmd, script[i].addr, script[i].data,
                                  script[i].lidx);
            if (script[i].typed) want = script[i].want;
            offer(script[i].cmd, script[i].addr, script[i].data, script[i].lidx, want);
        end

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: apply_setting(1'b0, 3'd0, RAM_SIZE_NONE);
                1: apply_setting(1'b1, 3'd0, RAM_SIZE_2K);
                2: apply_setting(1'b1, 3'd2, RAM_SIZE_8K);
                3: apply_setting(1'b0, 3'd6, RAM_SIZE_32K);
                7: apply_setting(1'b1, 3'd6, RAM_SIZE_32K);
                default: apply_setting(1'($urandom_range(0, 1)), 3'($urandom_range(0, 6)),
                                       2'($urandom_range(0, 3)));
            endcase
            if (p == 2) begin
                // stall results long enough for the block to back up
                hold_req = 1'b1;
                gaps_on  = 1'b0;
                repeat (40) random_access();
                gaps_on  = 1'b1;
            end
            if (p == 7) steady = 1'b1;
            phase_end = sent + PHASE_ITEMS;
            while (sent < phase_end) random_access();
        end

        s_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("[rom_ram_bank_controller] OK");
        else
            $display("[rom_ram_bank_controller] ERROR");
        $finish;
    end

endmodule
